// ===== sv/srpq_pkg.sv =====
// Shared types and constants for the sorted ring priority queue.
// Used by srpq_cell and sorted_ring_priority_queue; depends on nothing.
`timescale 1ns / 1ps

package srpq_pkg;

  // Queue geometry
  localparam int DEPTH       = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [COUNT_WIDTH-1:0]       count_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic  insert;
    logic  remove;
    data_t value;
  } cell_cmd_t;

  // What a cell shows to both neighbors
  typedef struct packed {
    logic  valid;
    logic  greater;
    data_t data;
  } cell_link_t;

endpackage

// ===== sv/srpq_cell.sv =====
// One storage cell of the sorted chain: holds one entry and its valid bit.
// Depends on srpq_pkg for the command and link structs.
`timescale 1ns / 1ps

module srpq_cell
  import srpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_cmd_t  cmd,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t link
);

  logic  valid;
  data_t data;
  logic  valid_next;
  data_t data_next;
  logic  greater;

  // Flag an entry that must move up to make room for the new value
  assign greater = valid && (data >= cmd.value);

  assign link.valid   = valid;
  assign link.greater = greater;
  assign link.data    = data;

  // Pick the next entry: shift up, take the new value, shift down or hold
  always_comb begin
    valid_next = valid;
    data_next  = data;
    if (cmd.insert) begin
      if (left.greater) begin
        valid_next = 1'b1;
        data_next  = left.data;
      end else if (greater || (!valid && left.valid)) begin
        valid_next = 1'b1;
        data_next  = cmd.value;
      end
    end else if (cmd.remove) begin
      valid_next = right.valid;
      data_next  = right.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Keep the chain sorted ascending toward the right
  assert property (@(posedge clk) disable iff (rst)
    valid && right.valid |-> data <= right.data)
    else $error("srpq_cell: chain out of order");

  // Keep valid entries packed toward the left
  assert property (@(posedge clk) disable iff (rst)
    valid |-> left.valid)
    else $error("srpq_cell: gap in chain");

  // A stalled cell holds its entry
  assert property (@(posedge clk) disable iff (rst)
    !cmd.insert && !cmd.remove |=> $stable(valid) && (!valid || $stable(data)))
    else $error("srpq_cell: entry changed while idle");

endmodule

// ===== sv/sorted_ring_priority_queue.sv =====
// Top level of the sorted priority queue: a chain of srpq_cell instances,
// the entry counter and the registered result beat. Depends on srpq_pkg.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive command and value_in with start high; the beat is
//   taken at a rising edge where start is high and busy is low. busy is high
//   only while rst is asserted, so a new command may be issued every cycle.
//   command 0 inserts value_in in sorted order, command 1 removes the smallest
//   entry. Up to DEPTH (16) entries are held.
//   Result channel: done pulses for one cycle, in the cycle after the
//   command beat, with status, value_out and item_count. The receiver cannot
//   stall; it must take the beat in that cycle.
//   Throughput is 1 command per cycle while busy is low: every cell of the
//   chain compares against the new value in parallel and shifts by one place
//   in the same edge, so no search loop sets the rate.
//   Status: 0 done, 1 insert rejected (full), 2 remove rejected (empty).
//   value_out is the removed smallest entry, else zero; item_count is the
//   number of entries held after the command.
//   Reset (synchronous rst) empties the queue and clears done; no clearing
//   pass is needed, since in the cells only the valid bits are reset.
module sorted_ring_priority_queue
  import srpq_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command,
  input  logic signed [DATA_WIDTH-1:0] value_in,
  output logic                         done,
  output logic [1:0]                   status,
  output logic signed [DATA_WIDTH-1:0] value_out,
  output logic [COUNT_WIDTH-1:0]       item_count
);

  logic       accept;
  logic       full;
  logic       empty;
  count_t     count;
  count_t     count_next;
  cell_cmd_t  cmd;
  cell_link_t links [DEPTH];
  cell_link_t edge_left;
  cell_link_t edge_right;
  logic [DEPTH-1:0] valid_vec;
  logic [1:0] status_next;
  data_t      value_next;

  assign busy   = rst;
  assign accept = start && !busy;
  assign full   = (count == count_t'(DEPTH));
  assign empty  = (count == '0);

  // Broadcast the operation to the chain
  assign cmd.insert = accept && (command == CMD_INSERT) && !full;
  assign cmd.remove = accept && (command == CMD_REMOVE) && !empty;
  assign cmd.value  = value_in;

  // Chain ends: always-valid, never-shifting head; empty slot past the tail
  assign edge_left.valid    = 1'b1;
  assign edge_left.greater  = 1'b0;
  assign edge_left.data     = '0;
  assign edge_right.valid   = 1'b0;
  assign edge_right.greater = 1'b0;
  assign edge_right.data    = '0;

  // Build the chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t left_link;
    cell_link_t right_link;
    if (i == 0) begin : g_first
      assign left_link = edge_left;
    end else begin : g_mid_l
      assign left_link = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_link = edge_right;
    end else begin : g_mid_r
      assign right_link = links[i+1];
    end
    srpq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  (left_link),
      .right (right_link),
      .link  (links[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  // Advance the entry count
  always_comb begin
    count_next = count;
    if (cmd.insert) begin
      count_next = count + count_t'(1);
    end else if (cmd.remove) begin
      count_next = count - count_t'(1);
    end
  end

  // Form the result beat
  always_comb begin
    status_next = ST_DONE;
    value_next  = '0;
    if (command == CMD_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        value_next = links[0].data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Hold the result payload for its beat
  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      value_out  <= value_next;
      item_count <= count_next;
    end
  end

  // Count matches the number of valid cells
  assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("sorted_ring_priority_queue: count does not match chain");

  // A result beat follows every command beat, and only then
  assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("sorted_ring_priority_queue: missing result beat");

  assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("sorted_ring_priority_queue: spurious result beat");

  // A full rejection reports a full queue
  assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FULL) |-> item_count == count_t'(DEPTH))
    else $error("sorted_ring_priority_queue: full reject with room left");

endmodule
